### src/mal_pkg.sv
`default_nettype none
package mal_pkg;

  localparam int ADDR_W  = 48;
  localparam int SLOT_W  = 3;
  localparam int ENTRY_W = 4;
  localparam int REJ_W   = 32;
  localparam int OC_W    = 3;

  // action codes
  localparam logic ACT_CHECK = 1'b0;
  localparam logic ACT_CLEAR = 1'b1;

  // outcome codes
  localparam logic [OC_W-1:0] OC_KNOWN         = 3'd0;
  localparam logic [OC_W-1:0] OC_LEARNED       = 3'd1;
  localparam logic [OC_W-1:0] OC_REJ_SEALED    = 3'd2;
  localparam logic [OC_W-1:0] OC_REJ_FULL      = 3'd3;
  localparam logic [OC_W-1:0] OC_CLEARED       = 3'd4;
  localparam logic [OC_W-1:0] OC_CLEAR_REFUSED = 3'd5;

  typedef struct packed {
    logic              action;
    logic [ADDR_W-1:0] mac_address;
  } in_item_t;

  typedef struct packed {
    logic               accepted;
    logic [OC_W-1:0]    outcome;
    logic [SLOT_W-1:0]  slot;
    logic [REJ_W-1:0]   rejection_total;
    logic [ENTRY_W-1:0] entry_total;
  } out_item_t;

  // sequencer to table control
  typedef struct packed {
    logic rd_en;
    logic learn;
    logic clear;
  } tbl_cmd_t;

endpackage
`default_nettype wire

### src/mac_allowlist_learning_table.sv
// latency: a check item's result is registered once the scan over the table ends,
// early on a hit; a clear item skips the scan; both wait in ST_DONE for a free result
// throughput: one item at a time; the next item is taken only back in ST_IDLE,
// after the previous item's result has been registered
// the single 48-bit comparator walks the store one slot per cycle
// reset: synchronous, clears the table, rejection counter and sealed flag
`default_nettype none
module mac_allowlist_learning_table #(
  parameter int TABLE_DEPTH = 8
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire mal_pkg::in_item_t  in_item,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output mal_pkg::out_item_t      out_item,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic               cfg_sealed
);
  import mal_pkg::*;

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  state_t           state_r, state_nxt;
  in_item_t         item_r, item_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;          // next slot to read
  logic             cmp_live_r, cmp_live_nxt; // a read is in the compare stage
  logic [IDX_W-1:0] cmp_idx_r, cmp_idx_nxt;
  logic             hit_r, hit_nxt;
  logic [IDX_W-1:0] hit_idx_r, hit_idx_nxt;
  logic             free_r, free_nxt;         // lowest free slot seen
  logic [IDX_W-1:0] free_idx_r, free_idx_nxt;
  logic [REJ_W-1:0] rej_r, rej_nxt;
  logic             sealed_r;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_item_r, out_item_nxt;

  tbl_cmd_t          cmd;
  logic [IDX_W-1:0]  wr_idx;
  logic [ADDR_W-1:0] rd_data;
  logic              rd_valid;
  logic [CNT_W-1:0]  entry_count;

  logic        in_take;
  logic        cmp_hit;
  logic        cmp_last;
  logic        out_free;
  logic [31:0] ent_sum;
  logic [31:0] slot_w;

  mal_table #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .IDX_W       (IDX_W),
    .CNT_W       (CNT_W)
  ) u_table (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .rd_idx      (idx_r[IDX_W-1:0]),
    .wr_idx      (wr_idx),
    .wr_addr     (item_r.mac_address),
    .rd_data     (rd_data),
    .rd_valid    (rd_valid),
    .entry_count (entry_count)
  );

  // one item in flight; result register parts the output side
  assign in_stall  = (state_r != ST_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign cfg_ready = (state_r == ST_IDLE);
  assign out_free  = !out_valid_r || !out_stall;

  // shared comparator on the registered read data
  assign cmp_hit  = cmp_live_r && rd_valid && (rd_data == item_r.mac_address);
  assign cmp_last = (cmp_idx_r == IDX_W'(TABLE_DEPTH - 1));

  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    idx_nxt       = idx_r;
    cmp_live_nxt  = 1'b0;
    cmp_idx_nxt   = cmp_idx_r;
    hit_nxt       = hit_r;
    hit_idx_nxt   = hit_idx_r;
    free_nxt      = free_r;
    free_idx_nxt  = free_idx_r;
    rej_nxt       = rej_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_item_nxt  = out_item_r;
    cmd           = '0;
    wr_idx        = free_idx_r;
    ent_sum       = 32'(entry_count);
    slot_w        = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          item_nxt = in_item;
          idx_nxt  = '0;
          hit_nxt  = 1'b0;
          free_nxt = 1'b0;
          // clear needs no walk over the table
          state_nxt = (in_item.action == ACT_CLEAR) ? ST_DONE : ST_SCAN;
        end
      end

      ST_SCAN: begin
        // lowest free slot, picked up as entries pass the compare stage
        if (cmp_live_r && !rd_valid && !free_r) begin
          free_nxt     = 1'b1;
          free_idx_nxt = cmp_idx_r;
        end
        if (cmp_hit) begin
          hit_nxt     = 1'b1;
          hit_idx_nxt = cmp_idx_r;
          state_nxt   = ST_DONE;
        end else if (cmp_live_r && cmp_last) begin
          state_nxt = ST_DONE;
        end else if (idx_r != CNT_W'(TABLE_DEPTH)) begin
          // issue the next read while the previous one is compared
          cmd.rd_en    = 1'b1;
          cmp_live_nxt = 1'b1;
          cmp_idx_nxt  = idx_r[IDX_W-1:0];
          idx_nxt      = idx_r + 1'b1;
        end
      end

      ST_DONE: begin
        // commit the table update only once the result register is free
        if (out_free) begin
          out_item_nxt = '0;
          if (item_r.action == ACT_CLEAR) begin
            if (sealed_r) begin
              out_item_nxt.outcome = OC_CLEAR_REFUSED;
            end else begin
              cmd.clear            = 1'b1;
              rej_nxt              = '0;
              ent_sum              = '0;
              out_item_nxt.outcome = OC_CLEARED;
            end
          end else if (hit_r) begin
            out_item_nxt.accepted = 1'b1;
            out_item_nxt.outcome  = OC_KNOWN;
            slot_w                = 32'(hit_idx_r);
          end else if (sealed_r) begin
            rej_nxt              = rej_r + 1'b1;
            out_item_nxt.outcome = OC_REJ_SEALED;
          end else if (free_r) begin
            cmd.learn             = 1'b1;
            wr_idx                = free_idx_r;
            ent_sum               = 32'(entry_count) + 32'd1;
            out_item_nxt.accepted = 1'b1;
            out_item_nxt.outcome  = OC_LEARNED;
            slot_w                = 32'(free_idx_r);
          end else begin
            rej_nxt              = rej_r + 1'b1;
            out_item_nxt.outcome = OC_REJ_FULL;
          end
          // slot and entry total carry only their low bits
          out_item_nxt.slot            = slot_w[SLOT_W-1:0];
          out_item_nxt.entry_total     = ent_sum[ENTRY_W-1:0];
          out_item_nxt.rejection_total = rej_nxt;
          out_valid_nxt                = 1'b1;
          state_nxt                    = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cmp_live_r  <= 1'b0;
      hit_r       <= 1'b0;
      free_r      <= 1'b0;
      idx_r       <= '0;
      rej_r       <= '0;
      sealed_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cmp_live_r  <= cmp_live_nxt;
      hit_r       <= hit_nxt;
      free_r      <= free_nxt;
      idx_r       <= idx_nxt;
      rej_r       <= rej_nxt;
      out_valid_r <= out_valid_nxt;
      // roster freeze, written only while idle
      if (cfg_valid && cfg_ready) begin
        sealed_r <= cfg_sealed;
      end
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    cmp_idx_r  <= cmp_idx_nxt;
    hit_idx_r  <= hit_idx_nxt;
    free_idx_r <= free_idx_nxt;
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule
`default_nettype wire

### src/mal_table.sv
`default_nettype none
module mal_table #(
  parameter int TABLE_DEPTH = 8,
  parameter int IDX_W       = 3,
  parameter int CNT_W       = 4
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire mal_pkg::tbl_cmd_t         cmd,
  input  wire logic [IDX_W-1:0]          rd_idx,
  input  wire logic [IDX_W-1:0]          wr_idx,
  input  wire logic [mal_pkg::ADDR_W-1:0] wr_addr,
  output logic [mal_pkg::ADDR_W-1:0]     rd_data,
  output logic                           rd_valid,
  output logic [CNT_W-1:0]               entry_count
);
  import mal_pkg::*;

  logic [TABLE_DEPTH-1:0] valid_r;
  logic [CNT_W-1:0]       count_r;
  logic [ADDR_W-1:0]      mem [TABLE_DEPTH];
  logic [ADDR_W-1:0]      rd_data_r;
  logic                   rd_valid_r;

  // valid bits and fill count, cleared together
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      count_r <= '0;
    end else if (cmd.clear) begin
      valid_r <= '0;
      count_r <= '0;
    end else if (cmd.learn) begin
      valid_r[wr_idx] <= 1'b1;
      count_r         <= count_r + 1'b1;
    end
  end

  // address store, registered read
  always_ff @(posedge clk) begin
    if (cmd.learn) begin
      mem[wr_idx] <= wr_addr;
    end
    if (cmd.rd_en) begin
      rd_data_r  <= mem[rd_idx];
      rd_valid_r <= valid_r[rd_idx];
    end
  end

  assign rd_data     = rd_data_r;
  assign rd_valid    = rd_valid_r;
  assign entry_count = count_r;

`ifndef SYNTH
  a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
    32'(count_r) == $countones(valid_r))
    else $error("fill count differs from valid bits");

  a_learn_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.learn |-> !valid_r[wr_idx])
    else $error("learn into an occupied slot");

  a_learn_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.learn |=> count_r == $past(count_r) + 1'b1)
    else $error("learn did not grow the table");
`endif

endmodule
`default_nettype wire

### sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import mal_pkg::*;

  localparam int DEPTH          = 8;
  localparam int HOLD_CYCLES    = 200;   // long receiver hold-off for the pressure test
  localparam int WATCHDOG_LIMIT = 4000;  // cycles with no handshake at all
  localparam int RANDOM_PHASES  = 16;
  localparam int PHASE_ITEMS    = 100;
  localparam int POOL_SIZE      = 12;    // more than DEPTH so the open table fills up

  // clock and reset
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  // block ports, all known from time zero
  logic      in_valid   = 1'b0;
  logic      in_stall;
  in_item_t  in_item    = '0;
  logic      out_valid;
  logic      out_stall  = 1'b0;
  out_item_t out_item;
  logic      cfg_valid  = 1'b0;
  logic      cfg_ready;
  logic      cfg_sealed = 1'b0;

  // shadow copy of the allow-list, fed at each accepted item
  logic              roster_valid [DEPTH];
  logic [ADDR_W-1:0] roster_addr  [DEPTH];
  logic [REJ_W-1:0]  refusal_count;
  logic              seal_model;

  out_item_t expected_verdicts[$];
  out_item_t want;

  // bookkeeping
  int fail_count    = 0;
  int items_sent    = 0;
  int results_seen  = 0;
  int seal_writes   = 0;
  int outcome_tally [6];
  int stuck_cycles  = 0;

  // shared knobs between the test tasks and the receiver
  bit no_idle  = 1'b0;  // when set neither side idles
  bit hold_req = 1'b0;  // asks the receiver for one long hold-off

  mac_allowlist_learning_table #(
    .TABLE_DEPTH(DEPTH)
  ) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_sealed(cfg_sealed)
  );

  initial begin : clock_gen
    forever #10 clk = ~clk;
  end

  // expected verdict for one item; updates the shadow table as the block would
  function automatic out_item_t predict_verdict(input in_item_t it);
    out_item_t r;
    int        hit;
    int        free_slot;
    int        n;
    r         = '0;
    hit       = -1;
    free_slot = -1;
    n         = 0;
    if (it.action == ACT_CLEAR) begin
      // a sealed roster refuses the clear and keeps its counter
      if (seal_model) begin
        r.outcome = OC_CLEAR_REFUSED;
      end else begin
        for (int i = 0; i < DEPTH; i++) begin
          roster_valid[i] = 1'b0;
          roster_addr[i]  = '0;
        end
        refusal_count = '0;
        r.outcome     = OC_CLEARED;
      end
    end else begin
      // walk downward so the lowest matching and lowest free slot win
      for (int i = DEPTH - 1; i >= 0; i--) begin
        if (roster_valid[i] && roster_addr[i] == it.mac_address) hit = i;
        if (!roster_valid[i]) free_slot = i;
      end
      if (hit >= 0) begin
        r.accepted = 1'b1;
        r.outcome  = OC_KNOWN;
        r.slot     = hit[SLOT_W-1:0];
      end else if (seal_model) begin
        refusal_count = refusal_count + 1'b1;
        r.outcome     = OC_REJ_SEALED;
      end else if (free_slot >= 0) begin
        roster_valid[free_slot] = 1'b1;
        roster_addr[free_slot]  = it.mac_address;
        r.accepted = 1'b1;
        r.outcome  = OC_LEARNED;
        r.slot     = free_slot[SLOT_W-1:0];
      end else begin
        refusal_count = refusal_count + 1'b1;
        r.outcome     = OC_REJ_FULL;
      end
    end
    for (int i = 0; i < DEPTH; i++) begin
      if (roster_valid[i]) n++;
    end
    r.rejection_total = refusal_count;
    r.entry_total     = n[ENTRY_W-1:0];
    return r;
  endfunction

  task automatic report_field(input string name, input logic [63:0] exp_v,
                              input logic [63:0] got_v);
    if (exp_v !== got_v) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp_v, got_v);
      fail_count++;
    end
  endtask

  // scoreboard: checks each accepted result, then records accepted items and
  // seal writes; everything samples the values from before the edge
  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DEPTH; i++) begin
        roster_valid[i] = 1'b0;
        roster_addr[i]  = '0;
      end
      refusal_count = '0;
      seal_model    = 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_verdicts.size() == 0) begin
          $display("%0t: result with nothing expected, actual %0h", $time, out_item);
          fail_count++;
        end else begin
          want = expected_verdicts.pop_front();
          report_field("accepted", want.accepted, out_item.accepted);
          report_field("outcome", want.outcome, out_item.outcome);
          report_field("slot", want.slot, out_item.slot);
          report_field("rejection_total", want.rejection_total,
                       out_item.rejection_total);
          report_field("entry_total", want.entry_total, out_item.entry_total);
          if (want.outcome <= OC_CLEAR_REFUSED) outcome_tally[want.outcome]++;
        end
      end
      if (cfg_valid && cfg_ready) seal_model = cfg_sealed;
      if (in_valid && !in_stall) expected_verdicts.push_back(predict_verdict(in_item));
    end
  end

  // result side: random stalls, or one long hold-off when asked
  initial begin : result_receiver
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_stall <= !no_idle && ($urandom_range(0, 99) < 22);
      end
    end
  end

  // watchdog: ends the run when no channel moves for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, stuck_cycles);
      $display("Test completed with failures");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // offer one item, maybe after a random gap, and return at its acceptance;
  // valid stays high so a following item can go out without a bubble
  task automatic send_item(input logic act, input logic [ADDR_W-1:0] addr);
    if (!no_idle && $urandom_range(0, 99) < 22) begin
      in_valid <= 1'b0;
      do @(posedge clk); while (!no_idle && $urandom_range(0, 99) < 22);
    end
    in_valid <= 1'b1;
    in_item  <= '{action: act, mac_address: addr};
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  // drop valid in the step of the last acceptance and wait for every result
  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_verdicts.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic write_seal_flag(input logic v);
    drain_results();
    cfg_valid  <= 1'b1;
    cfg_sealed <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
    seal_writes++;
  endtask

  // empty table: extreme addresses learned, then a hit, then a clear
  task automatic test_learning_empty();
    send_item(ACT_CHECK, '0);
    send_item(ACT_CHECK, '1);
    send_item(ACT_CHECK, '0);
    // address is ignored on a clear
    send_item(ACT_CLEAR, 48'hA5A5_5A5A_F00F);
    drain_results();
  endtask

  // fill every slot, overflow once, then hit the first and last slot
  task automatic test_fill_to_full();
    for (int i = 0; i < DEPTH; i++) send_item(ACT_CHECK, 48'h1 << (i * 6));
    send_item(ACT_CHECK, 48'hDEAD_BEEF_0042);
    send_item(ACT_CHECK, 48'h1 << ((DEPTH - 1) * 6));
    send_item(ACT_CHECK, 48'h1);
    drain_results();
  endtask

  // sealed roster: known passes, unknown is rejected, clear is refused; then open, clear and learn
  task automatic test_sealed_roster();
    write_seal_flag(1'b1);
    send_item(ACT_CHECK, 48'h1 << 18);
    send_item(ACT_CHECK, '1);
    send_item(ACT_CLEAR, '1);
    write_seal_flag(1'b0);
    send_item(ACT_CLEAR, '0);
    send_item(ACT_CHECK, '1);
    drain_results();
  endtask

  // receiver holds off for a long stretch while items keep coming
  task automatic test_backpressure();
    hold_req = 1'b1;
    send_item(ACT_CLEAR, '0);
    for (int i = 0; i < 11; i++) send_item(ACT_CHECK, 48'h0000_0C00_0000 + i);
    drain_results();
  endtask

  // phases of random traffic over a small address pool, sealed and open
  task automatic test_random_traffic();
    logic [ADDR_W-1:0] pool [POOL_SIZE];
    logic [63:0]       wide;
    logic [ADDR_W-1:0] base;
    int                roll;
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      if (ph == 0)      write_seal_flag(1'b0);
      else if (ph == 1) write_seal_flag(1'b1);
      else              write_seal_flag($urandom_range(0, 99) < 30);
      // one phase runs with neither side idling
      no_idle = (ph == 2);
      wide = {$urandom(), $urandom()};
      base = wide[ADDR_W-1:0];
      for (int k = 0; k < POOL_SIZE; k++) begin
        wide = {$urandom(), $urandom()};
        // half the pool are near misses of one base address
        if (k % 2 == 0) pool[k] = base ^ (48'h1 << $urandom_range(0, ADDR_W - 1));
        else            pool[k] = wide[ADDR_W-1:0];
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        roll = $urandom_range(0, 99);
        wide = {$urandom(), $urandom()};
        if (roll < 4)       send_item(ACT_CLEAR, wide[ADDR_W-1:0]);
        else if (roll < 84) send_item(ACT_CHECK, pool[$urandom_range(0, POOL_SIZE - 1)]);
        else                send_item(ACT_CHECK, wide[ADDR_W-1:0]);
      end
      drain_results();
    end
    no_idle = 1'b0;
  endtask

  initial begin : main_sequence
    for (int i = 0; i < 6; i++) outcome_tally[i] = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    test_learning_empty();
    test_fill_to_full();
    test_sealed_roster();
    test_backpressure();
    test_random_traffic();

    // nothing should arrive after the last expected result
    drain_results();
    repeat (2 * DEPTH + 8) @(posedge clk);
    if (expected_verdicts.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, expected_verdicts.size());
      fail_count++;
    end

    $display("covered %0d items, %0d results, %0d seal writes, open and sealed roster",
             items_sent, results_seen, seal_writes);
    $display("outcomes: known %0d learned %0d sealed-reject %0d full-reject %0d",
             outcome_tally[OC_KNOWN], outcome_tally[OC_LEARNED],
             outcome_tally[OC_REJ_SEALED], outcome_tally[OC_REJ_FULL]);
    $display("outcomes: cleared %0d clear-refused %0d, mismatches %0d",
             outcome_tally[OC_CLEARED], outcome_tally[OC_CLEAR_REFUSED], fail_count);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
